// File: rtl/gbsp_pkg.sv
// Shared constants, command codes and helpers for the gamepad button shift port.
// No dependencies; used by gamepad_button_shift_port_top.
package gbsp_pkg;

	// Command codes carried by each input transaction
	typedef enum logic [1:0] {
		CMD_POTGO = 2'd0,
		CMD_PORT  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [15:0] KEEP_MASK = 16'h5500;
	localparam logic [15:0] TAKE_MASK = 16'haa00;

	// Bit positions for pad 0; pad 1 sits PAD_STRIDE bits higher
	localparam int P5_DATA_BIT   = 8;
	localparam int P5_ENABLE_BIT = 9;
	localparam int P9_DATA_BIT   = 10;
	localparam int P9_ENABLE_BIT = 11;
	localparam int PAD_STRIDE    = 4;
	localparam int CLOCK_BIT     = 6;
	localparam int NUM_PADS      = 2;

	localparam int COUNT_W = 4;
	localparam logic [COUNT_W-1:0] COUNT_FULL = 4'd8;
	localparam logic [COUNT_W-1:0] COUNT_MIN_BUTTON = 4'd2;

	typedef logic [COUNT_W-1:0] count_t;

	// P5 is driven high when its enable and data bits are both set
	function automatic logic p5_held(input logic [15:0] pc, input int pad);
		p5_held = pc[P5_ENABLE_BIT + PAD_STRIDE * pad] & pc[P5_DATA_BIT + PAD_STRIDE * pad];
	endfunction

endpackage

// File: rtl/gamepad_button_shift_port_top.sv
// Gamepad button shift port: pot-go control word, per-pad shift counters and clock edges.
// A pot-data read's result is registered before it shows on read_data. Throughput: one
// transaction per cycle while in_stall is low; the state update is a single pass of bit logic
// between the state registers and the result register, with a one-entry skid stage behind it.
// Reset (arst_n low, asynchronous): control word, counters and clock levels clear to zero,
// the result and skid stages empty. Depends on gbsp_pkg.
module gamepad_button_shift_port_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] pot_write_data,
	input  logic [7:0]  port_pins,
	input  logic [7:0]  port_direction,
	input  logic [15:0] read_base,
	input  logic [6:0]  pad_buttons,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] read_data
);

	// Architectural state
	logic [15:0]            pot_control_q;
	gbsp_pkg::count_t       shift_count_q [gbsp_pkg::NUM_PADS];
	logic [gbsp_pkg::NUM_PADS-1:0] last_clock_q;

	// Result register and skid stage
	logic        res_valid_q;
	logic [15:0] res_data_q;
	logic        skid_valid_q;
	logic [15:0] skid_data_q;

	// Next-state and result of the transaction in flight
	logic [15:0]            pot_control_d;
	gbsp_pkg::count_t       shift_count_d [gbsp_pkg::NUM_PADS];
	logic [gbsp_pkg::NUM_PADS-1:0] last_clock_d;
	logic [15:0]            result;
	logic                   result_valid;
	logic                   in_accept;
	logic                   out_take;

	// Stall input only when both output stages are occupied
	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid & ~in_stall;
	assign out_take  = res_valid_q & ~out_stall;
	assign out_valid = res_valid_q;
	assign read_data = res_data_q;

	// Command decode and state update, all in one pass
	always_comb begin
		logic [15:0]      take_bits;
		logic [15:0]      sel_mask;
		logic             level;
		logic             fall;
		logic [2:0]       btn_idx;
		gbsp_pkg::count_t cnt;

		pot_control_d = pot_control_q;
		shift_count_d = shift_count_q;
		last_clock_d  = last_clock_q;
		result        = read_base;
		result_valid  = 1'b0;
		take_bits     = pot_write_data & gbsp_pkg::TAKE_MASK;
		sel_mask      = take_bits >> 1;
		level         = 1'b0;
		fall          = 1'b0;
		btn_idx       = '0;
		cnt           = '0;

		if (in_accept) begin
			case (gbsp_pkg::cmd_t'(cmd))
				gbsp_pkg::CMD_POTGO: begin
					// Keep the data bits, take the enables, and take data where enabled
					pot_control_d = (pot_control_q & gbsp_pkg::KEEP_MASK) | take_bits;
					pot_control_d = (pot_control_d & ~sel_mask) | (pot_write_data & sel_mask);
					for (int p = 0; p < gbsp_pkg::NUM_PADS; p++) begin
						if (gbsp_pkg::p5_held(pot_control_d, p)) begin
							shift_count_d[p] = gbsp_pkg::COUNT_FULL;
						end
					end
				end
				gbsp_pkg::CMD_PORT: begin
					// Count down on falling clock edges of output-enabled clock pins while P5 is not held
					for (int p = 0; p < gbsp_pkg::NUM_PADS; p++) begin
						level = port_pins[gbsp_pkg::CLOCK_BIT + p];
						fall  = port_direction[gbsp_pkg::CLOCK_BIT + p] & ~level
							& last_clock_q[p] & ~gbsp_pkg::p5_held(pot_control_q, p);
						if (fall && shift_count_q[p] != '0) begin
							shift_count_d[p] = shift_count_q[p] - gbsp_pkg::count_t'(1);
						end
						last_clock_d[p] = level;
					end
				end
				gbsp_pkg::CMD_READ: begin
					result_valid = 1'b1;
					for (int p = 0; p < gbsp_pkg::NUM_PADS; p++) begin
						result[gbsp_pkg::P5_DATA_BIT + gbsp_pkg::PAD_STRIDE * p] =
							pot_control_q[gbsp_pkg::P5_DATA_BIT + gbsp_pkg::PAD_STRIDE * p];
						if (!pot_control_q[gbsp_pkg::P9_ENABLE_BIT + gbsp_pkg::PAD_STRIDE * p]) begin
							result[gbsp_pkg::P9_DATA_BIT + gbsp_pkg::PAD_STRIDE * p] = 1'b1;
						end
						cnt = shift_count_q[p];
						if (gbsp_pkg::p5_held(pot_control_q, p)) begin
							cnt = gbsp_pkg::COUNT_FULL;
						end
						shift_count_d[p] = cnt;
						if (cnt == '0) begin
							result[gbsp_pkg::P9_DATA_BIT + gbsp_pkg::PAD_STRIDE * p] = 1'b0;
						end
						// Only pad 0 has a button source
						if (p == 0 && cnt >= gbsp_pkg::COUNT_MIN_BUTTON
							&& cnt <= gbsp_pkg::COUNT_FULL) begin
							btn_idx = 3'(cnt - gbsp_pkg::COUNT_MIN_BUTTON);
							if (pad_buttons[btn_idx]) begin
								result[gbsp_pkg::P9_DATA_BIT] = 1'b0;
							end
						end
					end
				end
				default: begin
					// Unused command: drop the transaction
				end
			endcase
		end
	end

	// Architectural state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pot_control_q <= '0;
			for (int p = 0; p < gbsp_pkg::NUM_PADS; p++) begin
				shift_count_q[p] <= '0;
			end
			last_clock_q <= '0;
		end else begin
			pot_control_q <= pot_control_d;
			shift_count_q <= shift_count_d;
			last_clock_q  <= last_clock_d;
		end
	end

	// Output stage occupancy: new results go to the result register unless it
	// holds a result that is not leaving; then they park in the skid stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (result_valid) begin
				if (res_valid_q && !out_take) begin
					skid_valid_q <= 1'b1;
				end else begin
					res_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Output payload, no reset needed
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				res_data_q <= skid_data_q;
			end
		end else if (result_valid) begin
			if (res_valid_q && !out_take) begin
				skid_data_q <= result;
			end else begin
				res_data_q <= result;
			end
		end
	end

	// The skid stage only fills behind an occupied result register
	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> res_valid_q)
		else $error("skid stage full with empty result register");

	// Counters never exceed the preset value
	assert property (@(posedge clk) disable iff (!arst_n)
		shift_count_q[0] <= gbsp_pkg::COUNT_FULL && shift_count_q[1] <= gbsp_pkg::COUNT_FULL)
		else $error("shift counter out of range");

	// A pot-go write that drives pad 0 P5 high presets its counter
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && cmd == gbsp_pkg::CMD_POTGO
			&& pot_write_data[gbsp_pkg::P5_ENABLE_BIT] && pot_write_data[gbsp_pkg::P5_DATA_BIT])
		|=> shift_count_q[0] == gbsp_pkg::COUNT_FULL)
		else $error("pad 0 counter not preset by pot-go write");

	// An accepted read always leaves out_valid high in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && cmd == gbsp_pkg::CMD_READ) |=> out_valid)
		else $error("read transaction lost");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for gamepad_button_shift_port_top: pot-go, port-A and pot-data
// transactions are checked against a behavioral copy of the port's state.
// Depends on gbsp_pkg and the RTL top level; reads no files.
`timescale 1ns / 1ps

module testbench;

	// One input transaction, every payload field carried whatever the command
	typedef struct {
		gbsp_pkg::cmd_t op;
		logic [15:0]    pot_word;
		logic [7:0]     pins;
		logic [7:0]     dir;
		logic [15:0]    base;
		logic [6:0]     buttons;
	} port_access_t;

	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int RANDOM_PER_PHASE = 400;
	localparam int SETTLE_CYCLES    = 10;
	localparam int RESET_CYCLES     = 6;

	// Clock, reset and DUT ports; every input holds a known value from time zero
	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd            = gbsp_pkg::CMD_NONE;
	logic [15:0] pot_write_data = '0;
	logic [7:0]  port_pins      = '0;
	logic [7:0]  port_direction = '0;
	logic [15:0] read_base      = '0;
	logic [6:0]  pad_buttons    = '0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic [15:0] read_data;

	// Stimulus waiting for the driver, and the transaction it currently offers
	port_access_t pending[$];
	port_access_t in_flight;

	// Pot-data words the port owes us, oldest first
	logic [15:0] read_expect[$];

	// Behavioral copy of the port state
	logic [15:0]      pot_ctrl;
	gbsp_pkg::count_t shift_cnt[gbsp_pkg::NUM_PADS];
	logic             clk_level[gbsp_pkg::NUM_PADS];

	int sender_idle_pct;
	int receiver_idle_pct;
	int stim_count;
	int fail_count;
	int reads_checked;
	int potgo_seen;
	int port_seen;
	int read_seen;
	int none_seen;
	int quiet_cycles;
	logic [15:0] want;

	gamepad_button_shift_port_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.pot_write_data (pot_write_data),
		.port_pins      (port_pins),
		.port_direction (port_direction),
		.read_base      (read_base),
		.pad_buttons    (pad_buttons),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_data      (read_data)
	);

	always #10 clk = ~clk;

	// P5 counts as driven high only with both its enable and its data bit set
	function automatic logic p5_driven(input int pad);
		return pot_ctrl[gbsp_pkg::P5_ENABLE_BIT + gbsp_pkg::PAD_STRIDE * pad]
			& pot_ctrl[gbsp_pkg::P5_DATA_BIT + gbsp_pkg::PAD_STRIDE * pad];
	endfunction

	// Advance the port state by one transaction; return 1 when it yields a pot-data word
	function automatic logic step_port(input port_access_t t, output logic [15:0] word);
		int   o;
		logic lvl;
		word = '0;
		case (t.op)
		gbsp_pkg::CMD_POTGO: begin
			// Keep the data half, take the enable half, then let enabled pins load data
			word = (pot_ctrl & gbsp_pkg::KEEP_MASK) | (t.pot_word & gbsp_pkg::TAKE_MASK);
			for (int pin = 0; pin < 8; pin += 2)
				if (t.pot_word[gbsp_pkg::P5_ENABLE_BIT + pin])
					word[gbsp_pkg::P5_DATA_BIT + pin] = t.pot_word[gbsp_pkg::P5_DATA_BIT + pin];
			pot_ctrl = word;
			for (int pad = 0; pad < gbsp_pkg::NUM_PADS; pad++)
				if (p5_driven(pad))
					shift_cnt[pad] = gbsp_pkg::COUNT_FULL;
			return 1'b0;
		end
		gbsp_pkg::CMD_PORT: begin
			for (int pad = 0; pad < gbsp_pkg::NUM_PADS; pad++) begin
				lvl = t.pins[gbsp_pkg::CLOCK_BIT + pad];
				// Step down on a falling edge of an output clock pin, saturating at zero
				if (!p5_driven(pad) && t.dir[gbsp_pkg::CLOCK_BIT + pad] && clk_level[pad]
						&& !lvl && shift_cnt[pad] != 0)
					shift_cnt[pad] = shift_cnt[pad] - 1'b1;
				clk_level[pad] = lvl;
			end
			return 1'b0;
		end
		gbsp_pkg::CMD_READ: begin
			word = t.base;
			for (int pad = 0; pad < gbsp_pkg::NUM_PADS; pad++) begin
				o = gbsp_pkg::PAD_STRIDE * pad;
				word[gbsp_pkg::P5_DATA_BIT + o] = pot_ctrl[gbsp_pkg::P5_DATA_BIT + o];
				if (!pot_ctrl[gbsp_pkg::P9_ENABLE_BIT + o])
					word[gbsp_pkg::P9_DATA_BIT + o] = 1'b1;
				if (p5_driven(pad))
					shift_cnt[pad] = gbsp_pkg::COUNT_FULL;
				if (shift_cnt[pad] == 0)
					word[gbsp_pkg::P9_DATA_BIT + o] = 1'b0;
				// Only pad 0 has buttons; count value 1 leaves P9 alone
				if (pad == 0 && shift_cnt[0] >= gbsp_pkg::COUNT_MIN_BUTTON
						&& shift_cnt[0] <= gbsp_pkg::COUNT_FULL
						&& t.buttons[3'(shift_cnt[0] - gbsp_pkg::COUNT_MIN_BUTTON)])
					word[gbsp_pkg::P9_DATA_BIT + o] = 1'b0;
			end
			return 1'b1;
		end
		default:
			return 1'b0;
		endcase
	endfunction

	task automatic queue_access(input gbsp_pkg::cmd_t op, input logic [15:0] pot_word,
			input logic [7:0] pins, input logic [7:0] dir, input logic [15:0] base,
			input logic [6:0] buttons);
		port_access_t t;
		t.op       = op;
		t.pot_word = pot_word;
		t.pins     = pins;
		t.dir      = dir;
		t.base     = base;
		t.buttons  = buttons;
		pending.push_back(t);
		if (op != gbsp_pkg::CMD_NONE)
			stim_count++;
	endtask

	// Hold until the driver is empty and every pot-data word has come back
	task automatic wait_drained();
		do @(negedge clk);
		while (pending.size() != 0 || in_valid || read_expect.size() != 0);
	endtask

	// Mostly well-formed button shifts: load pads with P5 high, release P5, then clock
	// out a random number of bits with reads in between. The rest is random noise.
	task automatic fill_random(input int n);
		int          target;
		int          pulses;
		logic [15:0] w;
		logic [7:0]  p;
		logic [7:0]  d;
		target = stim_count + n;
		while (stim_count < target) begin
			if ($urandom_range(0, 3) != 0) begin
				w = 16'($urandom);
				if ($urandom_range(0, 3) != 0) begin
					w[gbsp_pkg::P5_ENABLE_BIT] = 1'b1;
					w[gbsp_pkg::P5_DATA_BIT]   = 1'b1;
				end
				if ($urandom_range(0, 1) != 0) begin
					w[gbsp_pkg::P5_ENABLE_BIT + gbsp_pkg::PAD_STRIDE] = 1'b1;
					w[gbsp_pkg::P5_DATA_BIT + gbsp_pkg::PAD_STRIDE]   = 1'b1;
				end
				queue_access(gbsp_pkg::CMD_POTGO, w, 8'($urandom), 8'($urandom),
					16'($urandom), 7'($urandom));
				if ($urandom_range(0, 2) == 0)
					queue_access(gbsp_pkg::CMD_READ, 16'($urandom), 8'($urandom),
						8'($urandom), 16'($urandom), 7'($urandom));
				// Release P5: data low, enable either set (drives low) or clear
				w = 16'($urandom);
				w[gbsp_pkg::P5_DATA_BIT]                       = 1'b0;
				w[gbsp_pkg::P5_DATA_BIT + gbsp_pkg::PAD_STRIDE] = 1'b0;
				queue_access(gbsp_pkg::CMD_POTGO, w, 8'($urandom), 8'($urandom),
					16'($urandom), 7'($urandom));
				pulses = $urandom_range(1, 10);
				repeat (pulses) begin
					d = 8'($urandom);
					d[gbsp_pkg::CLOCK_BIT]     = ($urandom_range(0, 7) != 0);
					d[gbsp_pkg::CLOCK_BIT + 1] = ($urandom_range(0, 7) != 0);
					p = 8'($urandom);
					p[gbsp_pkg::CLOCK_BIT]     = 1'b1;
					p[gbsp_pkg::CLOCK_BIT + 1] = 1'b1;
					queue_access(gbsp_pkg::CMD_PORT, 16'($urandom), p, d, 16'($urandom),
						7'($urandom));
					p = 8'($urandom);
					p[gbsp_pkg::CLOCK_BIT]     = 1'b0;
					p[gbsp_pkg::CLOCK_BIT + 1] = 1'b0;
					queue_access(gbsp_pkg::CMD_PORT, 16'($urandom), p, d, 16'($urandom),
						7'($urandom));
					if ($urandom_range(0, 9) < 7)
						queue_access(gbsp_pkg::CMD_READ, 16'($urandom), 8'($urandom),
							8'($urandom), 16'($urandom), 7'($urandom));
				end
			end else begin
				queue_access(gbsp_pkg::cmd_t'($urandom_range(0, 3)), 16'($urandom),
					8'($urandom), 8'($urandom), 16'($urandom), 7'($urandom));
			end
		end
	endtask

	// Driver: offer the next pending transaction, hold the payload while stalled,
	// and feed the model at the edge where the port takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				case (in_flight.op)
				gbsp_pkg::CMD_POTGO: potgo_seen++;
				gbsp_pkg::CMD_PORT:  port_seen++;
				gbsp_pkg::CMD_READ:  read_seen++;
				default:             none_seen++;
				endcase
				if (step_port(in_flight, want))
					read_expect.push_back(want);
			end
			if (!in_valid || !in_stall) begin
				if (pending.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					in_flight = pending.pop_front();
					cmd            <= in_flight.op;
					pot_write_data <= in_flight.pot_word;
					port_pins      <= in_flight.pins;
					port_direction <= in_flight.dir;
					read_base      <= in_flight.base;
					pad_buttons    <= in_flight.buttons;
					in_valid       <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest expected pot-data word,
	// then pick a fresh stall level for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (read_expect.size() == 0) begin
					$error("read_data: no result expected, got %h", read_data);
					fail_count++;
				end else begin
					reads_checked++;
					if (read_data !== read_expect[0]) begin
						$error("read_data: expected %h, got %h", read_expect[0], read_data);
						fail_count++;
					end
					void'(read_expect.pop_front());
				end
			end
			out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
		end
	end

	// Watchdog: end the run if no transaction moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles, %0d results outstanding",
				quiet_cycles, read_expect.size());
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		pot_ctrl          = '0;
		shift_cnt[0]      = '0;
		shift_cnt[1]      = '0;
		clk_level[0]      = 1'b0;
		clk_level[1]      = 1'b0;
		stim_count        = 0;
		fail_count        = 0;
		reads_checked     = 0;
		potgo_seen        = 0;
		port_seen         = 0;
		read_seen         = 0;
		none_seen         = 0;
		quiet_cycles      = 0;
		sender_idle_pct   = 36;
		receiver_idle_pct = 66;

		// Directed: reads with empty counters, the unused code, a full load with P5
		// held (clock ignored), release, then step the count down through every
		// button position to 1 and to 0.
		queue_access(gbsp_pkg::CMD_READ,  16'h0000, 8'h00, 8'h00, 16'hffff, 7'h7f);
		queue_access(gbsp_pkg::CMD_NONE,  16'hffff, 8'hff, 8'hff, 16'hffff, 7'h7f);
		queue_access(gbsp_pkg::CMD_POTGO, 16'hffff, 8'h00, 8'h00, 16'h0000, 7'h00);
		queue_access(gbsp_pkg::CMD_READ,  16'h0000, 8'h00, 8'h00, 16'h0000, 7'h7f);
		queue_access(gbsp_pkg::CMD_PORT,  16'h0000, 8'h00, 8'hff, 16'h0000, 7'h00);
		queue_access(gbsp_pkg::CMD_POTGO, 16'h2200, 8'h00, 8'h00, 16'h0000, 7'h00);
		queue_access(gbsp_pkg::CMD_PORT,  16'h0000, 8'hc0, 8'hff, 16'h0000, 7'h00);
		queue_access(gbsp_pkg::CMD_PORT,  16'h0000, 8'h00, 8'hff, 16'h0000, 7'h00);
		queue_access(gbsp_pkg::CMD_READ,  16'h0000, 8'h00, 8'h00, 16'h0000, 7'h20);
		repeat (6) begin
			queue_access(gbsp_pkg::CMD_PORT, 16'h0000, 8'hc0, 8'hff, 16'h0000, 7'h00);
			queue_access(gbsp_pkg::CMD_PORT, 16'h0000, 8'h00, 8'hff, 16'h0000, 7'h00);
		end
		queue_access(gbsp_pkg::CMD_READ,  16'h0000, 8'h00, 8'h00, 16'h0000, 7'h7f);
		queue_access(gbsp_pkg::CMD_PORT,  16'h0000, 8'hff, 8'hff, 16'h0000, 7'h00);
		queue_access(gbsp_pkg::CMD_PORT,  16'h0000, 8'h3f, 8'hff, 16'h0000, 7'h00);
		queue_access(gbsp_pkg::CMD_READ,  16'hffff, 8'hff, 8'hff, 16'hffff, 7'h00);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		// Three stall mixes; drain fully after each so the sender pauses until
		// every expected result is back.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin
				sender_idle_pct   = 36;
				receiver_idle_pct = 66;
			end
			1: begin
				sender_idle_pct   = 66;
				receiver_idle_pct = 36;
			end
			default: begin
				sender_idle_pct   = 0;
				receiver_idle_pct = 0;
			end
			endcase
			fill_random(RANDOM_PER_PHASE);
			wait_drained();
		end

		// Let any stray result show up before judging
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (read_expect.size() != 0) begin
			$error("read_data: %0d expected results never arrived", read_expect.size());
			fail_count++;
		end

		$display("Accepted %0d pot-go writes, %0d port-A writes, %0d reads, %0d unused codes",
			potgo_seen, port_seen, read_seen, none_seen);
		$display("Checked %0d pot-data words under three stall mixes, %0d mismatches",
			reads_checked, fail_count);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
